[rtl/pecc_pkg.sv]
// Shared types, constants and widths for the polygon edge turn classifier.
package pecc_pkg;

   localparam int COORD_W = 32;
   localparam int ID_W = 32;
   localparam int CNT_W = 32;
   localparam int DIFF_W = COORD_W + 1;
   localparam int LO_W = 16;
   localparam int HI_W = DIFF_W - LO_W;
   localparam int PROD_W = 2 * DIFF_W;
   localparam int RSP_BITS = 8 * COORD_W + ID_W + 4;
   localparam int RSP_W = ((RSP_BITS + 7) / 8) * 8;

   typedef enum logic [1:0] {
      TURN_RIGHT    = 2'd0,
      TURN_LEFT     = 2'd1,
      TURN_STRAIGHT = 2'd2
   } turn_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
   } vertex_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] min_x;
      logic signed [COORD_W-1:0] max_x;
      logic signed [COORD_W-1:0] min_y;
      logic signed [COORD_W-1:0] max_y;
   } box_type;

   localparam logic [COORD_W-1:0] COORD_TOP = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic [COORD_W-1:0] COORD_BOT = {1'b1, {(COORD_W-1){1'b0}}};
   localparam box_type BOX_CLEAR = '{
      min_x: COORD_TOP, max_x: COORD_BOT, min_y: COORD_TOP, max_y: COORD_BOT};

   // Mask bit 0 is the edge ending at the previous vertex, bit 1 the edge into the
   // closing vertex, bit 2 the closing edge and bit 3 the first edge of the polygon.
   typedef struct packed {
      vertex_type v_old;
      vertex_type v_new;
      vertex_type v_p;
      vertex_type v_first;
      vertex_type v_second;
      box_type box;
      logic [ID_W-1:0] id_a;
      logic [ID_W-1:0] id_b;
      logic [ID_W-1:0] id_c;
      logic [ID_W-1:0] id_d;
      turn_type a_st;
      turn_type a_et;
      turn_type b_st;
      turn_type b_et;
      turn_type c_st;
      turn_type c_et;
      turn_type d_st;
      turn_type d_et;
      logic [3:0] mask;
   } seg_entry_type;

   typedef struct packed {
      logic valid;
      seg_entry_type entry;
   } q_push_type;

endpackage

[rtl/pecc_turn.sv]
// Pipelined exact orientation test: the sign of (b - a) x (c - a) in four stages.
module pecc_turn import pecc_pkg::*; (
   input  logic       clock,
   input  logic       enable,
   input  vertex_type a,
   input  vertex_type b,
   input  vertex_type c,
   output turn_type   turn
);

   logic signed [DIFF_W-1:0]   d_ff [4];
   logic signed [DIFF_W-1:0]   d_in [4];
   logic signed [2*HI_W-1:0]   hh_ff [2];
   logic signed [2*HI_W-1:0]   hl_ff [2];
   logic signed [2*HI_W-1:0]   lh_ff [2];
   logic        [2*LO_W-1:0]   ll_ff [2];
   logic signed [PROD_W-1:0]   prod_ff [2];
   turn_type                   turn_ff;

   always_comb begin
      d_in[0] = {b.x[COORD_W-1], b.x} - {a.x[COORD_W-1], a.x};
      d_in[1] = {c.y[COORD_W-1], c.y} - {a.y[COORD_W-1], a.y};
      d_in[2] = {b.y[COORD_W-1], b.y} - {a.y[COORD_W-1], a.y};
      d_in[3] = {c.x[COORD_W-1], c.x} - {a.x[COORD_W-1], a.x};
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int i = 0; i < 4; i++) begin
            d_ff[i] <= d_in[i];
         end
         for (int i = 0; i < 2; i++) begin
            hh_ff[i] <= $signed(d_ff[2*i][DIFF_W-1:LO_W])
                        * $signed(d_ff[2*i+1][DIFF_W-1:LO_W]);
            hl_ff[i] <= $signed(d_ff[2*i][DIFF_W-1:LO_W])
                        * $signed({1'b0, d_ff[2*i+1][LO_W-1:0]});
            lh_ff[i] <= $signed({1'b0, d_ff[2*i][LO_W-1:0]})
                        * $signed(d_ff[2*i+1][DIFF_W-1:LO_W]);
            ll_ff[i] <= d_ff[2*i][LO_W-1:0] * d_ff[2*i+1][LO_W-1:0];
         end
         for (int i = 0; i < 2; i++) begin
            prod_ff[i] <= {hh_ff[i], {(2*LO_W){1'b0}}}
               + {{(PROD_W-2*HI_W-LO_W){hl_ff[i][2*HI_W-1]}}, hl_ff[i], {LO_W{1'b0}}}
               + {{(PROD_W-2*HI_W-LO_W){lh_ff[i][2*HI_W-1]}}, lh_ff[i], {LO_W{1'b0}}}
               + {{(PROD_W-2*LO_W){1'b0}}, ll_ff[i]};
         end
         priority if (prod_ff[0] == prod_ff[1]) begin
            turn_ff <= TURN_STRAIGHT;
         end else if (prod_ff[0] > prod_ff[1]) begin
            turn_ff <= TURN_LEFT;
         end else begin
            turn_ff <= TURN_RIGHT;
         end
      end
   end

   assign turn = turn_ff;

endmodule

[rtl/pecc_front.sv]
// Front end: vertex tracking, bounding box, numbering and the turn pipeline.
module pecc_front import pecc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,
   input  logic        req_tlast,
   input  logic        req_tuser,
   input  logic        q_full,
   output q_push_type  push
);

   typedef struct packed {
      seg_entry_type e;
      logic has_turn;
      logic k_two;
      logic close_two;
   } stage_type;

   function automatic box_type box_grow(input box_type bx, input vertex_type v);
      box_type r;
      r = bx;
      if ($signed(v.x) < $signed(bx.min_x)) r.min_x = v.x;
      if ($signed(v.x) > $signed(bx.max_x)) r.max_x = v.x;
      if ($signed(v.y) < $signed(bx.min_y)) r.min_y = v.y;
      if ($signed(v.y) > $signed(bx.max_y)) r.max_y = v.y;
      return r;
   endfunction

   logic [CNT_W-1:0] count_ff, count_in, n_cnt;
   logic [ID_W-1:0]  base_ff, base_in, base_eff;
   box_type          box_ff, box_in, box_eff;
   vertex_type       first_ff, first_in, second_ff, second_in;
   vertex_type       older_ff, older_in, newer_ff, newer_in, p;
   turn_type         tao_ff, tas_ff, tas_cur;
   turn_type         t_cur, t_close, t_first;
   logic             k_zero, k_one, k_two, close_two, close_many;
   logic             accept, adv, need_push;
   stage_type        st_in, s4;
   stage_type        pipe_ff [5];
   logic [4:0]       pv_ff;
   seg_entry_type    res;

   always_comb begin
      p.x = req_tdata[31:0];
      p.y = req_tdata[63:32];
      base_eff = req_tuser ? '0 : base_ff;
      box_eff = req_tuser ? BOX_CLEAR : box_ff;
      k_zero = (count_ff == '0);
      k_one = (count_ff == CNT_W'(1));
      k_two = (count_ff == CNT_W'(2));
      n_cnt = (count_ff == '1) ? count_ff : count_ff + CNT_W'(1);
      close_two = req_tlast && (n_cnt == CNT_W'(2));
      close_many = req_tlast && (n_cnt >= CNT_W'(3));

      first_in = k_zero ? p : first_ff;
      second_in = k_one ? p : second_ff;
      older_in = older_ff;
      newer_in = newer_ff;
      if (k_one) begin
         older_in = first_ff;
         newer_in = p;
         box_in = box_grow(box_grow(box_eff, first_ff), p);
      end else if (k_zero) begin
         box_in = box_eff;
      end else begin
         older_in = newer_ff;
         newer_in = p;
         box_in = box_grow(box_eff, p);
      end

      count_in = req_tlast ? '0 : n_cnt;
      if (close_two) begin
         base_in = base_eff + ID_W'(1);
      end else if (close_many) begin
         base_in = base_eff + ID_W'(n_cnt);
      end else begin
         base_in = base_eff;
      end

      st_in.e.v_old = older_ff;
      st_in.e.v_new = newer_ff;
      st_in.e.v_p = p;
      st_in.e.v_first = first_in;
      st_in.e.v_second = second_in;
      st_in.e.box = box_in;
      st_in.e.id_a = base_eff + ID_W'(count_ff) - ID_W'(2);
      st_in.e.id_b = base_eff + ID_W'(n_cnt) - ID_W'(2);
      st_in.e.id_c = base_eff + ID_W'(n_cnt) - ID_W'(1);
      st_in.e.id_d = base_eff;
      st_in.e.a_st = TURN_RIGHT;
      st_in.e.a_et = TURN_RIGHT;
      st_in.e.b_st = TURN_RIGHT;
      st_in.e.b_et = TURN_RIGHT;
      st_in.e.c_st = TURN_RIGHT;
      st_in.e.c_et = TURN_RIGHT;
      st_in.e.d_st = TURN_RIGHT;
      st_in.e.d_et = TURN_RIGHT;
      st_in.e.mask = {close_two || close_many, close_many, close_many,
                      !k_zero && !k_one && !k_two};
      st_in.has_turn = !k_zero && !k_one;
      st_in.k_two = k_two;
      st_in.close_two = close_two;
   end

   always_comb begin
      s4 = pipe_ff[4];
      tas_cur = s4.k_two ? t_cur : tas_ff;
      res = s4.e;
      res.a_st = tao_ff;
      res.a_et = t_cur;
      res.b_st = t_cur;
      res.b_et = t_close;
      res.c_st = t_close;
      res.c_et = t_first;
      if (s4.close_two) begin
         res.d_st = TURN_LEFT;
         res.d_et = TURN_LEFT;
      end else begin
         res.d_st = t_first;
         res.d_et = tas_cur;
      end
      need_push = pv_ff[4] && (s4.e.mask != '0);
      adv = !(need_push && q_full);
      accept = req_tvalid && adv;
      push.valid = need_push && adv;
      push.entry = res;
   end

   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         base_ff <= '0;
         box_ff <= BOX_CLEAR;
      end else if (accept) begin
         count_ff <= count_in;
         base_ff <= base_in;
         box_ff <= box_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         first_ff <= first_in;
         second_ff <= second_in;
         older_ff <= older_in;
         newer_ff <= newer_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= '0;
         tao_ff <= TURN_RIGHT;
         tas_ff <= TURN_RIGHT;
      end else if (adv) begin
         pv_ff <= {pv_ff[3:0], req_tvalid};
         if (pv_ff[4] && s4.has_turn) begin
            tao_ff <= t_cur;
            if (s4.k_two) begin
               tas_ff <= t_cur;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pipe_ff[0] <= st_in;
         for (int i = 1; i < 5; i++) begin
            pipe_ff[i] <= pipe_ff[i-1];
         end
      end
   end

   pecc_turn u_turn_cur (
      .clock  (clock),
      .enable (adv),
      .a      (pipe_ff[0].e.v_old),
      .b      (pipe_ff[0].e.v_new),
      .c      (pipe_ff[0].e.v_p),
      .turn   (t_cur)
   );

   pecc_turn u_turn_close (
      .clock  (clock),
      .enable (adv),
      .a      (pipe_ff[0].e.v_new),
      .b      (pipe_ff[0].e.v_p),
      .c      (pipe_ff[0].e.v_first),
      .turn   (t_close)
   );

   pecc_turn u_turn_first (
      .clock  (clock),
      .enable (adv),
      .a      (pipe_ff[0].e.v_p),
      .b      (pipe_ff[0].e.v_first),
      .c      (pipe_ff[0].e.v_second),
      .turn   (t_first)
   );

   assert property (@(posedge clock) disable iff (reset)
      accept && req_tlast |=> count_ff == '0)
      else $error("Vertex count not cleared after a closing vertex.");

   assert property (@(posedge clock) disable iff (reset)
      pv_ff[4] && s4.e.mask[1] |-> s4.e.mask[2] && s4.e.mask[3] && !s4.close_two)
      else $error("Closing edges of a polygon are incomplete.");

   assert property (@(posedge clock) disable iff (reset)
      accept && !req_tlast && (count_ff != '1) |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("Vertex count did not advance.");

endmodule

[rtl/pecc_back.sv]
// Back end: segment queue, expansion into single edges and the output register.
module pecc_back import pecc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  q_push_type       push,
   output logic             q_full,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,
   output logic             rsp_tlast
);

   localparam int QDEPTH = 4;
   localparam int PTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   typedef enum logic [1:0] {SLOT_A, SLOT_B, SLOT_C, SLOT_D} slot_type;

   typedef struct packed {
      vertex_type s;
      vertex_type e;
      logic [ID_W-1:0] id;
      turn_type st;
      turn_type et;
      box_type box;
      logic last;
   } out_type;

   seg_entry_type    q_mem_ff [QDEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] cnt_ff;
   logic [3:0]       done_ff, rem, sel_bit;
   seg_entry_type    head;
   slot_type         slot;
   logic             load, pop, last;
   out_type          out_ff, out_in;
   logic             out_v_ff;

   always_comb begin
      head = q_mem_ff[rd_ptr_ff];
      rem = head.mask & ~done_ff;
      priority if (rem[0]) begin
         slot = SLOT_A;
      end else if (rem[1]) begin
         slot = SLOT_B;
      end else if (rem[2]) begin
         slot = SLOT_C;
      end else begin
         slot = SLOT_D;
      end
      sel_bit = 4'b0001 << slot;
      last = ((rem & ~sel_bit) == '0);
      load = (cnt_ff != '0) && (!out_v_ff || rsp_tready);
      pop = load && last;
      q_full = (cnt_ff == QCNT_W'(QDEPTH));

      out_in.box = head.box;
      out_in.last = last;
      unique case (slot)
         SLOT_A: begin
            out_in.s = head.v_old;
            out_in.e = head.v_new;
            out_in.id = head.id_a;
            out_in.st = head.a_st;
            out_in.et = head.a_et;
         end
         SLOT_B: begin
            out_in.s = head.v_new;
            out_in.e = head.v_p;
            out_in.id = head.id_b;
            out_in.st = head.b_st;
            out_in.et = head.b_et;
         end
         SLOT_C: begin
            out_in.s = head.v_p;
            out_in.e = head.v_first;
            out_in.id = head.id_c;
            out_in.st = head.c_st;
            out_in.et = head.c_et;
         end
         SLOT_D: begin
            out_in.s = head.v_first;
            out_in.e = head.v_second;
            out_in.id = head.id_d;
            out_in.st = head.d_st;
            out_in.et = head.d_et;
         end
         default: begin
            out_in.s = head.v_first;
            out_in.e = head.v_second;
            out_in.id = head.id_d;
            out_in.st = head.d_st;
            out_in.et = head.d_et;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         q_mem_ff[wr_ptr_ff] <= push.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff <= '0;
         done_ff <= '0;
         out_v_ff <= 1'b0;
      end else begin
         if (push.valid) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
            done_ff <= '0;
         end else if (load) begin
            done_ff <= done_ff | sel_bit;
         end
         if (push.valid && !pop) begin
            cnt_ff <= cnt_ff + QCNT_W'(1);
         end else if (pop && !push.valid) begin
            cnt_ff <= cnt_ff - QCNT_W'(1);
         end
         if (load) begin
            out_v_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_v_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_ff <= out_in;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tlast = out_ff.last;
   assign rsp_tdata = {{(RSP_W-RSP_BITS){1'b0}},
                       out_ff.box.max_y, out_ff.box.min_y,
                       out_ff.box.max_x, out_ff.box.min_x,
                       out_ff.et, out_ff.st, out_ff.id,
                       out_ff.e.y, out_ff.e.x, out_ff.s.y, out_ff.s.x};

   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QCNT_W'(QDEPTH))
      else $error("Segment queue overflowed.");

   assert property (@(posedge clock) disable iff (reset)
      push.valid |-> !q_full)
      else $error("Transfer into a full segment queue.");

   assert property (@(posedge clock) disable iff (reset)
      cnt_ff == '0 |-> done_ff == '0)
      else $error("Edge progress left over in an empty queue.");

endmodule

[rtl/polygon_edge_turn_classifier_unit.sv]
// Top level of the polygon edge turn classifier.
// The block takes one vertex per clock cycle and reports each polygon edge with
// its number, the turn class at both ends and the running bounding box. A vertex
// causes at most one edge, except the closing vertex, which causes up to four;
// these leave one per cycle from a four-entry queue while rsp_tready is high, and
// the input stalls only while that queue is full and the five-stage turn pipeline
// has a further group of edges waiting at its end. Turns are exact: each cross
// product comes from partial products of 17/16-bit halves over three stages.
module polygon_edge_turn_classifier_unit import pecc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // vertex_x [31:0], vertex_y [63:32]
   input  logic [63:0]      req_tdata,
   input  logic             req_tlast,
   // new_set [0]
   input  logic             req_tuser,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // start_x, start_y, end_x, end_y, segment_number (32 bits each), start_turn,
   // end_turn (2 bits each), box_min_x, box_max_x, box_min_y, box_max_y (32 bits
   // each), zero fill to the top
   output logic [RSP_W-1:0] rsp_tdata,
   output logic             rsp_tlast
);

   q_push_type push;
   logic       q_full;

   pecc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .push       (push)
   );

   pecc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .q_full     (q_full),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

[tb/sv/polygon_edge_turn_classifier_unit_checker.sv]
// Checker that predicts and compares every segment the polygon edge turn classifier reports.
module polygon_edge_turn_classifier_unit_checker import pecc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tready,
   input  logic [63:0]      req_tdata,
   input  logic             req_tlast,
   input  logic             req_tuser,
   input  logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  logic [RSP_W-1:0] rsp_tdata,
   input  logic             rsp_tlast,
   output int               fail_count,
   output int               outstanding
);

   typedef struct {
      vertex_type      from_v;
      vertex_type      to_v;
      logic [ID_W-1:0] number;
      turn_type        from_turn;
      turn_type        to_turn;
      box_type         bounds;
      logic            run_end;
   } segment_record_type;

   vertex_type         first_v, second_v, older_v, newer_v;
   turn_type           turn_older, turn_second;
   logic [CNT_W-1:0]   vcount;
   logic [ID_W-1:0]    base_id;
   box_type            bounds;
   segment_record_type pending_segments[$];
   int                 mismatches;

   function automatic turn_type turn_at(vertex_type a, vertex_type b, vertex_type c);
      logic signed [COORD_W:0]     bx, by, cx, cy;
      logic signed [2*COORD_W+1:0] lhs, rhs;
      bx = $signed(b.x) - $signed(a.x);
      by = $signed(b.y) - $signed(a.y);
      cx = $signed(c.x) - $signed(a.x);
      cy = $signed(c.y) - $signed(a.y);
      lhs = bx * cy;
      rhs = by * cx;
      if (lhs == rhs) begin
         return TURN_STRAIGHT;
      end
      return (lhs > rhs) ? TURN_LEFT : TURN_RIGHT;
   endfunction

   function automatic box_type widen(box_type bb, vertex_type p);
      box_type nb;
      nb = bb;
      if ($signed(p.x) < $signed(nb.min_x)) nb.min_x = p.x;
      if ($signed(p.x) > $signed(nb.max_x)) nb.max_x = p.x;
      if ($signed(p.y) < $signed(nb.min_y)) nb.min_y = p.y;
      if ($signed(p.y) > $signed(nb.max_y)) nb.max_y = p.y;
      return nb;
   endfunction

   function automatic segment_record_type form_segment(vertex_type s, vertex_type e,
                                                       logic [ID_W-1:0] id,
                                                       turn_type st, turn_type et);
      segment_record_type r;
      r.from_v = s;
      r.to_v = e;
      r.number = id;
      r.from_turn = st;
      r.to_turn = et;
      r.bounds = bounds;
      r.run_end = 1'b0;
      return r;
   endfunction

   task automatic predict_vertex(vertex_type p, logic closes, logic fresh);
      segment_record_type found[$];
      logic [CNT_W-1:0]   k, n;
      turn_type           t, tl, t0;
      k = vcount;
      if (fresh) begin
         bounds = BOX_CLEAR;
         base_id = '0;
      end
      if (k == 0) begin
         first_v = p;
      end else if (k == 1) begin
         second_v = p;
         bounds = widen(bounds, first_v);
         bounds = widen(bounds, p);
         older_v = first_v;
         newer_v = p;
      end else begin
         bounds = widen(bounds, p);
         t = turn_at(older_v, newer_v, p);
         if (k == 2) begin
            turn_second = t;
         end else begin
            found.push_back(form_segment(older_v, newer_v, base_id + k - 2, turn_older, t));
         end
         turn_older = t;
         older_v = newer_v;
         newer_v = p;
      end
      if (vcount != '1) vcount++;
      if (closes) begin
         n = vcount;
         if (n == 2) begin
            found.push_back(form_segment(first_v, second_v, base_id, TURN_LEFT, TURN_LEFT));
            base_id = base_id + 1;
         end else if (n >= 3) begin
            tl = turn_at(older_v, newer_v, first_v);
            t0 = turn_at(newer_v, first_v, second_v);
            found.push_back(form_segment(older_v, newer_v, base_id + n - 2, turn_older, tl));
            found.push_back(form_segment(newer_v, first_v, base_id + n - 1, tl, t0));
            found.push_back(form_segment(first_v, second_v, base_id, t0, turn_second));
            base_id = base_id + n;
         end
         vcount = '0;
      end
      if (found.size() > 0) found[found.size()-1].run_end = 1'b1;
      foreach (found[i]) pending_segments.push_back(found[i]);
   endtask

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %h, actual %h", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      segment_record_type want;
      vertex_type         p;
      if (reset) begin
         first_v = '0;
         second_v = '0;
         older_v = '0;
         newer_v = '0;
         turn_older = TURN_RIGHT;
         turn_second = TURN_RIGHT;
         vcount = '0;
         base_id = '0;
         bounds = BOX_CLEAR;
         pending_segments.delete();
         mismatches = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            p.x = req_tdata[31:0];
            p.y = req_tdata[63:32];
            predict_vertex(p, req_tlast, req_tuser);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_segments.size() == 0) begin
               $error("Segment transfer arrived with no segment expected.");
               mismatches++;
            end else begin
               want = pending_segments.pop_front();
               check_field("start_x", want.from_v.x, rsp_tdata[31:0]);
               check_field("start_y", want.from_v.y, rsp_tdata[63:32]);
               check_field("end_x", want.to_v.x, rsp_tdata[95:64]);
               check_field("end_y", want.to_v.y, rsp_tdata[127:96]);
               check_field("segment_number", want.number, rsp_tdata[159:128]);
               check_field("start_turn", want.from_turn, rsp_tdata[161:160]);
               check_field("end_turn", want.to_turn, rsp_tdata[163:162]);
               check_field("box_min_x", want.bounds.min_x, rsp_tdata[195:164]);
               check_field("box_max_x", want.bounds.max_x, rsp_tdata[227:196]);
               check_field("box_min_y", want.bounds.min_y, rsp_tdata[259:228]);
               check_field("box_max_y", want.bounds.max_y, rsp_tdata[291:260]);
               check_field("run_end", want.run_end, rsp_tlast);
            end
         end
      end
      fail_count <= mismatches;
      outstanding <= pending_segments.size();
   end

endmodule

[tb/sv/polygon_edge_turn_classifier_unit_tb.sv]
// Testbench top that streams polygon vertices into the classifier and gives the verdict.
module polygon_edge_turn_classifier_unit_tb;
   import pecc_pkg::*;

   localparam logic [31:0] CMIN = 32'h8000_0000;
   localparam logic [31:0] CMAX = 32'h7FFF_FFFF;
   localparam int RANDOM_VERTICES = 330;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [63:0]      req_tdata = '0;
   logic             req_tlast = 1'b0;
   logic             req_tuser = 1'b0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic             rsp_tlast;
   logic             steady = 1'b0;
   int               fail_count;
   int               outstanding;
   int               sent = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   polygon_edge_turn_classifier_unit DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tlast(req_tlast), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

   polygon_edge_turn_classifier_unit_checker checker_i (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tlast(req_tlast), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast), .fail_count(fail_count), .outstanding(outstanding)
   );

   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= 34);
   end

   task automatic push_vertex(logic [31:0] x, logic [31:0] y, logic closes, logic fresh);
      logic calm;
      calm = (sent >= 120 && sent < 200);
      steady <= calm;
      while (!calm && $urandom_range(99) < 34) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {y, x};
      req_tlast <= closes;
      req_tuser <= fresh;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent++;
   endtask

   function automatic logic [31:0] pick_coord(int mode);
      unique case (mode)
         0: return $urandom_range(40) - 20;
         1: return $urandom();
         default: begin
            unique case ($urandom_range(4))
               0: return CMIN;
               1: return CMAX;
               2: return '0;
               3: return '1;
               default: return $urandom();
            endcase
         end
      endcase
   endfunction

   initial begin
      int   shape, size, mode;
      logic closes, fresh;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // A lone vertex is dropped without touching the box.
      push_vertex(CMAX, CMIN, 1'b1, 1'b0);
      // A two-vertex polygon spanning the full coordinate range.
      push_vertex(CMIN, CMIN, 1'b0, 1'b0);
      push_vertex(CMAX, CMAX, 1'b1, 1'b0);
      // A collinear vertex inside a quadrilateral.
      push_vertex(32'd0, 32'd0, 1'b0, 1'b0);
      push_vertex(32'd1, 32'd1, 1'b0, 1'b0);
      push_vertex(32'd2, 32'd2, 1'b0, 1'b0);
      push_vertex(32'd5, 32'd0, 1'b1, 1'b0);
      // Clockwise square at the corners of the range.
      push_vertex(CMIN, CMIN, 1'b0, 1'b0);
      push_vertex(CMIN, CMAX, 1'b0, 1'b0);
      push_vertex(CMAX, CMAX, 1'b0, 1'b0);
      push_vertex(CMAX, CMIN, 1'b1, 1'b0);
      // Anticlockwise square at the corners of the range.
      push_vertex(CMIN, CMIN, 1'b0, 1'b0);
      push_vertex(CMAX, CMIN, 1'b0, 1'b0);
      push_vertex(CMAX, CMAX, 1'b0, 1'b0);
      push_vertex(CMIN, CMAX, 1'b1, 1'b0);
      // A new set that starts in the middle of an open polygon.
      push_vertex(32'd3, 32'd4, 1'b0, 1'b0);
      push_vertex(32'd5, -32'sd6, 1'b0, 1'b1);
      push_vertex(32'd7, 32'd8, 1'b1, 1'b0);
      // A new set on a first vertex, then a fully degenerate triangle.
      push_vertex(-32'sd1, 32'd9, 1'b0, 1'b1);
      push_vertex(32'd4, -32'sd2, 1'b0, 1'b0);
      push_vertex(32'd0, 32'd0, 1'b1, 1'b0);
      push_vertex(32'd7, 32'd7, 1'b0, 1'b0);
      push_vertex(32'd7, 32'd7, 1'b0, 1'b0);
      push_vertex(32'd7, 32'd7, 1'b1, 1'b0);

      sent = 0;
      while (sent < RANDOM_VERTICES) begin
         shape = $urandom_range(9);
         if (shape < 7) size = $urandom_range(3, 7);
         else if (shape < 9) size = $urandom_range(1, 2);
         else size = $urandom_range(8, 20);
         mode = $urandom_range(2);
         for (int i = 0; i < size; i++) begin
            fresh = ($urandom_range(15) == 0);
            closes = (i == size - 1);
            if ($urandom_range(30) == 0) closes = !closes;
            push_vertex(pick_coord(mode), pick_coord(mode), closes, fresh);
         end
      end
      req_tvalid <= 1'b0;
      steady <= 1'b0;

      while (outstanding != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("** polygon_edge_turn_classifier_unit: PASSED **");
      end else begin
         $display("** polygon_edge_turn_classifier_unit: FAILED **");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("** polygon_edge_turn_classifier_unit: FAILED **");
      $finish;
   end

endmodule
